// File: sv/pnrc_pkg.sv
package pnrc_pkg;

    localparam int NODES_DEF       = 8;
    localparam int SAMPLE_BITS_DEF = 64;
    localparam int MAX_OUT         = 8;

    localparam int REQ_W     = 1;
    localparam int NODE_ID_W = 8;
    localparam int DATA_W    = 64;
    localparam int TIME_W    = 32;
    localparam int OUT_ID_W  = 4;
    localparam int SPACING_W = 16;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd50;

    localparam logic [REQ_W-1:0] REQ_SAMPLE = 1'b0;
    localparam logic [REQ_W-1:0] REQ_TICK   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_FLUSH
    } t_state;

    // slot store strobes driven by the scan sequencer
    typedef struct packed {
        logic smp_we;
        logic time_we;
        logic rd_en;
    } t_mem_ctl;

endpackage

// File: sv/pnrc_slot_mem.sv
module pnrc_slot_mem #(
    parameter int NODES       = pnrc_pkg::NODES_DEF,
    parameter int SAMPLE_BITS = pnrc_pkg::SAMPLE_BITS_DEF,
    parameter int IDX_W       = (NODES > 1) ? $clog2(NODES) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pnrc_pkg::t_mem_ctl          i_ctl,
    input  logic [IDX_W-1:0]            i_wr_addr,
    input  logic [SAMPLE_BITS-1:0]      i_wr_sample,
    input  logic [pnrc_pkg::TIME_W-1:0] i_wr_time,
    input  logic [IDX_W-1:0]            i_rd_addr,
    output logic [SAMPLE_BITS-1:0]      o_rd_sample,
    output logic [pnrc_pkg::TIME_W-1:0] o_rd_time
);

    localparam int TIME_W = pnrc_pkg::TIME_W;

    logic [SAMPLE_BITS-1:0] r_sample_mem [NODES];
    logic [TIME_W-1:0]      r_time_mem   [NODES];
    logic [NODES-1:0]       r_time_ok;
    logic [SAMPLE_BITS-1:0] r_rd_sample;
    logic [TIME_W-1:0]      r_rd_time;

    always_ff @(posedge i_clk) begin
        if (i_ctl.smp_we) begin
            r_sample_mem[i_wr_addr] <= i_wr_sample;
        end
        if (i_ctl.time_we) begin
            r_time_mem[i_wr_addr] <= i_wr_time;
        end
    end

    // last publish time reads as zero until a node has published once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_ok <= '0;
        end else if (i_ctl.time_we) begin
            r_time_ok[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_sample <= r_sample_mem[i_rd_addr];
            r_rd_time   <= r_time_ok[i_rd_addr] ? r_time_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_sample = r_rd_sample;
    assign o_rd_time   = r_rd_time;

endmodule

// File: sv/per_node_rate_limited_conflation_core.sv
// sample word: written into its slot when taken; the block stays idle and ready for the next word
// tick word: each node slot goes through a memory read, then a due compare, and a
//   flush state closes the run; the scan ends early once MAX_OUT words are published
// a published word leaves once the next due node or the end of the scan is known
// synchronous active-low reset: all slots invalid, publish times zero, spacing 50
module per_node_rate_limited_conflation_core #(
    parameter int NODES       = pnrc_pkg::NODES_DEF,
    parameter int SAMPLE_BITS = pnrc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [pnrc_pkg::REQ_W-1:0]     i_req_type,
    input  logic [pnrc_pkg::NODE_ID_W-1:0] i_node_id,
    input  logic [pnrc_pkg::DATA_W-1:0]    i_sample_data,
    input  logic [pnrc_pkg::TIME_W-1:0]    i_now_ms,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pnrc_pkg::OUT_ID_W-1:0]  o_out_node_id,
    output logic [pnrc_pkg::DATA_W-1:0]    o_out_payload,
    output logic                           o_last_of_run,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pnrc_pkg::SPACING_W-1:0] i_cfg_data
);

    localparam int IDX_W     = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W     = $clog2(pnrc_pkg::MAX_OUT + 1);
    localparam int NODE_ID_W = pnrc_pkg::NODE_ID_W;
    localparam int DATA_W    = pnrc_pkg::DATA_W;
    localparam int TIME_W    = pnrc_pkg::TIME_W;
    localparam int OUT_ID_W  = pnrc_pkg::OUT_ID_W;
    localparam int SPACING_W = pnrc_pkg::SPACING_W;

    pnrc_pkg::t_state       r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [NODES-1:0]       r_valid;
    logic [SPACING_W-1:0]   r_spacing;
    logic [TIME_W-1:0]      r_now;
    logic                   r_pend_valid, n_pend_valid;
    logic [OUT_ID_W-1:0]    r_pend_node;
    logic [SAMPLE_BITS-1:0] r_pend_payload;
    logic                   r_out_valid;
    logic [OUT_ID_W-1:0]    r_out_node;
    logic [SAMPLE_BITS-1:0] r_out_payload;
    logic                   r_out_last;

    pnrc_pkg::t_mem_ctl     mem_ctl;
    logic                   in_stall;
    logic                   pend_load;
    logic                   out_load;
    logic                   out_last;
    logic                   clr_valid;
    logic                   id_ok;
    logic [NODE_ID_W-1:0]   id_minus1;
    logic [IDX_W-1:0]       id_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic [NODE_ID_W-1:0]   idx_plus1;
    logic                   last_idx;
    logic                   cnt_full;
    logic                   out_free;
    logic [TIME_W-1:0]      elapsed;
    logic                   due;
    logic [SAMPLE_BITS-1:0] rd_sample;
    logic [TIME_W-1:0]      rd_time;

    assign id_ok     = (i_node_id >= NODE_ID_W'(1)) && (i_node_id <= NODE_ID_W'(NODES));
    assign id_minus1 = i_node_id - NODE_ID_W'(1);
    assign id_addr   = id_minus1[IDX_W-1:0];
    assign wr_addr   = (r_state == pnrc_pkg::S_IDLE) ? id_addr : r_idx;
    assign idx_plus1 = NODE_ID_W'(r_idx) + NODE_ID_W'(1);
    assign last_idx  = (r_idx == IDX_W'(NODES - 1));
    assign cnt_full  = (r_cnt == CNT_W'(pnrc_pkg::MAX_OUT - 1));
    assign out_free  = !r_out_valid || !i_out_stall;

    // wrapping time since last publish against the spacing
    assign elapsed = r_now - rd_time;
    assign due     = r_valid[r_idx] && (elapsed >= TIME_W'(r_spacing));

    pnrc_slot_mem #(
        .NODES       (NODES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_slot_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mem_ctl),
        .i_wr_addr   (wr_addr),
        .i_wr_sample (i_sample_data[SAMPLE_BITS-1:0]),
        .i_wr_time   (r_now),
        .i_rd_addr   (r_idx),
        .o_rd_sample (rd_sample),
        .o_rd_time   (rd_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pnrc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        pend_load    = 1'b0;
        out_load     = 1'b0;
        out_last     = 1'b0;
        clr_valid    = 1'b0;
        in_stall     = 1'b1;
        mem_ctl      = '0;
        case (r_state)
            pnrc_pkg::S_IDLE: begin
                in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_req_type == pnrc_pkg::REQ_TICK) begin
                        n_idx   = '0;
                        n_cnt   = '0;
                        n_state = pnrc_pkg::S_READ;
                    end else if (id_ok) begin
                        mem_ctl.smp_we = 1'b1;
                    end
                end
            end
            pnrc_pkg::S_READ: begin
                mem_ctl.rd_en = 1'b1;
                n_state       = pnrc_pkg::S_CHECK;
            end
            pnrc_pkg::S_CHECK: begin
                if (due) begin
                    // a held word can only leave when the output register frees up
                    if (!r_pend_valid || out_free) begin
                        out_load        = r_pend_valid;
                        pend_load       = 1'b1;
                        n_pend_valid    = 1'b1;
                        clr_valid       = 1'b1;
                        mem_ctl.time_we = 1'b1;
                        n_cnt           = r_cnt + CNT_W'(1);
                        if (last_idx || cnt_full) begin
                            n_state = pnrc_pkg::S_FLUSH;
                        end else begin
                            n_idx   = r_idx + IDX_W'(1);
                            n_state = pnrc_pkg::S_READ;
                        end
                    end
                end else if (last_idx) begin
                    n_state = pnrc_pkg::S_FLUSH;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = pnrc_pkg::S_READ;
                end
            end
            pnrc_pkg::S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = pnrc_pkg::S_IDLE;
                end else if (out_free) begin
                    out_load     = 1'b1;
                    out_last     = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = pnrc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pnrc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_cnt        <= '0;
            r_valid      <= '0;
            r_spacing    <= pnrc_pkg::SPACING_RESET;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_spacing <= i_cfg_data;
            end
            if (mem_ctl.smp_we) begin
                r_valid[id_addr] <= 1'b1;
            end
            if (clr_valid) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pnrc_pkg::S_IDLE && i_in_valid) begin
            r_now <= i_now_ms;
        end
        if (pend_load) begin
            r_pend_node    <= idx_plus1[OUT_ID_W-1:0];
            r_pend_payload <= rd_sample;
        end
        if (out_load) begin
            r_out_node    <= r_pend_node;
            r_out_payload <= r_pend_payload;
            r_out_last    <= out_last;
        end
    end

    assign o_in_stall    = in_stall;
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_out_node_id = r_out_node;
    assign o_out_payload = DATA_W'(r_out_payload);
    assign o_last_of_run = r_out_last;

`ifndef ASSERT_OFF
    a_no_pend_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pnrc_pkg::S_IDLE) |-> !r_pend_valid)
        else $error("held word left behind after scan");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(pnrc_pkg::MAX_OUT))
        else $error("publish count above limit");

    a_publish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pnrc_pkg::S_CHECK && clr_valid) |=> !r_valid[$past(r_idx)])
        else $error("published slot still valid");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pnrc_pkg::S_FLUSH && r_pend_valid && out_free)
        |=> (r_out_valid && r_out_last && r_state == pnrc_pkg::S_IDLE))
        else $error("closing word not marked last");

    a_mid_scan_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pnrc_pkg::S_CHECK && out_load) |=> (r_out_valid && !r_out_last))
        else $error("mid-scan word marked last");
`endif

endmodule

// File: test/per_node_rate_limited_conflation_core_test.sv
`timescale 1ns / 100ps

module per_node_rate_limited_conflation_core_test;

    localparam int NODES       = pnrc_pkg::NODES_DEF;
    localparam int REQ_W       = pnrc_pkg::REQ_W;
    localparam int NODE_ID_W   = pnrc_pkg::NODE_ID_W;
    localparam int DATA_W      = pnrc_pkg::DATA_W;
    localparam int TIME_W      = pnrc_pkg::TIME_W;
    localparam int OUT_ID_W    = pnrc_pkg::OUT_ID_W;
    localparam int SPACING_W   = pnrc_pkg::SPACING_W;
    localparam int SCAN_WAIT   = 2 * NODES + 8;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [OUT_ID_W-1:0] node_id;
        logic [DATA_W-1:0]   payload;
        logic                last;
    } t_publish;

    class publish_predictor;
        logic [SPACING_W-1:0] spacing;
        bit                   fresh [NODES];
        logic [DATA_W-1:0]    latest [NODES];
        logic [TIME_W-1:0]    sent_at [NODES];
        t_publish             due_publishes [$];
        int                   errors;

        function new();
            spacing = pnrc_pkg::SPACING_RESET;
            errors  = 0;
            foreach (fresh[n]) begin
                fresh[n]   = 1'b0;
                latest[n]  = '0;
                sent_at[n] = '0;
            end
        endfunction

        function void note_word(input logic [REQ_W-1:0] req, input logic [NODE_ID_W-1:0] id,
                                input logic [DATA_W-1:0] data, input logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] gap;
            t_publish          pub;
            int                n;
            int                hits;
            hits = 0;
            if (req == pnrc_pkg::REQ_SAMPLE) begin
                // ids outside 1..NODES are dropped
                if (id >= 1 && id <= NODES) begin
                    latest[id - 1] = data;
                    fresh[id - 1]  = 1'b1;
                end
            end else begin
                for (n = 0; n < NODES && hits < pnrc_pkg::MAX_OUT; n++) begin
                    gap = now - sent_at[n];
                    if (fresh[n] && gap >= {16'd0, spacing}) begin
                        pub.node_id = OUT_ID_W'(n + 1);
                        pub.payload = latest[n];
                        pub.last    = 1'b0;
                        due_publishes.push_back(pub);
                        sent_at[n] = now;
                        fresh[n]   = 1'b0;
                        hits++;
                    end
                end
                if (hits > 0) begin
                    pub      = due_publishes.pop_back();
                    pub.last = 1'b1;
                    due_publishes.push_back(pub);
                end
            end
        endfunction

        function void check_publish(input logic [OUT_ID_W-1:0] id,
                                    input logic [DATA_W-1:0] payload, input logic last);
            t_publish want;
            if (due_publishes.size() == 0) begin
                $error("publish of node %0d while none is due", id);
                errors++;
            end else begin
                want = due_publishes.pop_front();
                if (id !== want.node_id) begin
                    $error("out_node_id: expected %0d, got %0d", want.node_id, id);
                    errors++;
                end
                if (payload !== want.payload) begin
                    $error("out_payload: expected %h, got %h", want.payload, payload);
                    errors++;
                end
                if (last !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, last);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return due_publishes.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [REQ_W-1:0]     i_req_type;
    logic [NODE_ID_W-1:0] i_node_id;
    logic [DATA_W-1:0]    i_sample_data;
    logic [TIME_W-1:0]    i_now_ms;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [OUT_ID_W-1:0]  o_out_node_id;
    logic [DATA_W-1:0]    o_out_payload;
    logic                 o_last_of_run;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [SPACING_W-1:0] i_cfg_data;

    publish_predictor  sb = new();
    int                send_gap_pct;
    int                recv_stall_pct;
    bit                hold_req;
    int                cycle_count;
    logic [TIME_W-1:0] wall_ms;

    per_node_rate_limited_conflation_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_node_id     (i_node_id),
        .i_sample_data (i_sample_data),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_node_id (o_out_node_id),
        .o_out_payload (o_out_payload),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // output side: random stall, or one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_publish(o_out_node_id, o_out_payload, o_last_of_run);
    end

    // caller is past a rising edge; the word is set up at a falling edge, after any random idle gaps
    task automatic send_word(input logic [REQ_W-1:0] req, input logic [NODE_ID_W-1:0] id,
                             input logic [DATA_W-1:0] data, input logic [TIME_W-1:0] now);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_node_id     <= id;
        i_sample_data <= data;
        i_now_ms      <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_word(req, id, data, now);
    endtask

    // unused fields carry noise
    task automatic send_sample(input logic [NODE_ID_W-1:0] id, input logic [DATA_W-1:0] data);
        send_word(pnrc_pkg::REQ_SAMPLE, id, data, $urandom);
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] now);
        send_word(pnrc_pkg::REQ_TICK, NODE_ID_W'($urandom_range(0, 255)),
                  {$urandom, $urandom}, now);
    endtask

    task automatic rest_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_for_publishes();
        rest_input();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_spacing(input logic [SPACING_W-1:0] value);
        wait_for_publishes();
        // a quiet tick may still be scanning
        repeat (SCAN_WAIT) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.spacing = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int pick;
        int k;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_sample(NODE_ID_W'($urandom_range(1, NODES)), {$urandom, $urandom});
            end else if (pick < 65) begin
                send_sample(NODE_ID_W'($urandom_range(0, 255)), {$urandom, $urandom});
            end else begin
                // mostly steady time, now and then a jump anywhere
                if ($urandom_range(9) == 0)
                    wall_ms = $urandom;
                else
                    wall_ms = wall_ms + $urandom_range(0, 2 * sb.spacing + 20);
                send_tick(wall_ms);
            end
            if ($urandom_range(49) == 0)
                wait_for_publishes();
        end
    endtask

    initial begin
        int n;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = pnrc_pkg::REQ_SAMPLE;
        i_node_id      = '0;
        i_sample_data  = '0;
        i_now_ms       = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        hold_req       = 1'b0;
        send_gap_pct   = 35;
        recv_stall_pct = 84;
        wall_ms        = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // quiet tick, then ids out of range, then a word for every node
        send_tick(32'd0);
        send_sample(8'd0, {$urandom, $urandom});
        send_sample(NODE_ID_W'(NODES + 1), {$urandom, $urandom});
        send_sample(8'hFF, {$urandom, $urandom});
        send_sample(8'd1, 64'd0);
        for (n = 2; n < NODES; n++)
            send_sample(NODE_ID_W'(n), {$urandom, $urandom});
        send_sample(NODE_ID_W'(NODES), {DATA_W{1'b1}});
        // start-up: publish times are zero, so 49 is too early and 50 is due
        send_tick(32'd49);
        send_tick(32'd50);
        // only the newest word of a node is kept
        send_sample(8'd1, {$urandom, $urandom});
        send_sample(8'd1, {$urandom, $urandom});
        send_sample(NODE_ID_W'(NODES), {$urandom, $urandom});
        send_tick(32'd99);
        send_tick(32'd100);
        send_tick(32'd101);
        send_sample(8'd4, {$urandom, $urandom});
        send_tick(32'hFFFF_FFFF);
        // wrapped gap of 33, then exactly the spacing
        send_sample(8'd4, {$urandom, $urandom});
        send_tick(32'h0000_0020);
        send_tick(32'h0000_0031);
        wall_ms = 32'h0000_0031;

        write_spacing(16'd0);
        run_random(150);

        send_gap_pct   = 84;
        recv_stall_pct = 35;
        write_spacing(16'hFFFF);
        run_random(150);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_spacing(SPACING_W'($urandom_range(1, 40)));
        wall_ms = 32'hFFFF_FF80;
        // long output hold-off: the scan backs up and the input stalls
        rest_input();
        hold_req = 1'b1;
        for (n = 1; n <= NODES; n++)
            send_sample(NODE_ID_W'(n), {$urandom, $urandom});
        wall_ms = wall_ms + 32'd100;
        send_tick(wall_ms);
        for (n = 1; n <= NODES; n++)
            send_sample(NODE_ID_W'(n), {$urandom, $urandom});
        wall_ms = wall_ms + 32'd100;
        send_tick(wall_ms);
        run_random(130);

        wait_for_publishes();
        repeat (SCAN_WAIT) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
sv/pnrc_pkg.sv
sv/pnrc_slot_mem.sv
sv/per_node_rate_limited_conflation_core.sv
test/per_node_rate_limited_conflation_core_test.sv
